// ----- hw/rtl/rbes_pkg.sv -----
// ----------------------------------------------------------------------------
// rbes_pkg: shared constants and types for the rigid body Euler step
// Fixed point format, register indexes, sequencer states and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

package rbes_pkg;

	localparam int FRAC_BITS = 16;
	// dividend width of the shared divider: a 32-bit magnitude shifted up
	localparam int DVD_W = 32 + FRAC_BITS;
	localparam int DCNT_W = $clog2(DVD_W);

	localparam logic [30:0] MASS_RST = 31'd1 << FRAC_BITS;
	localparam logic [30:0] FRIC_RST = 31'd100 << FRAC_BITS;
	localparam logic [30:0] LIMX_RST = 31'd100 << FRAC_BITS;
	localparam logic [30:0] LIMY_RST = 31'd600 << FRAC_BITS;

	typedef enum logic [2:0] {
		REG_MASS   = 3'd0,
		REG_FRIC_X = 3'd1,
		REG_FRIC_Y = 3'd2,
		REG_FRIC_Z = 3'd3,
		REG_LIM_X  = 3'd4,
		REG_LIM_Y  = 3'd5
	} reg_idx_t;

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_ALD   = 21'h000002,
		S_DIV   = 21'h000004,
		S_ACC   = 21'h000008,
		S_AMUL  = 21'h000010,
		S_AVEL  = 21'h000020,
		S_VCHK  = 21'h000040,
		S_SQM   = 21'h000080,
		S_SQA   = 21'h000100,
		S_ROOT  = 21'h000200,
		S_FLD   = 21'h000400,
		S_FS    = 21'h000800,
		S_FD    = 21'h001000,
		S_FM    = 21'h002000,
		S_MSM   = 21'h004000,
		S_MSA   = 21'h008000,
		S_FAPP  = 21'h010000,
		S_CLAMP = 21'h020000,
		S_PM    = 21'h040000,
		S_PA    = 21'h080000,
		S_OUT   = 21'h100000
	} state_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rigid_body_euler_step.sv -----
// ----------------------------------------------------------------------------
// rigid_body_euler_step: explicit Euler integration with friction
// One body, stored velocity, signed Q16.16 force/acceleration/position.
// ----------------------------------------------------------------------------
// Each input transfer runs to completion before the next is taken: the block
// drops in_ready from acceptance until its result transfer completes. The
// work goes through one 32x32 multiplier, one restoring divider (one quotient
// bit a cycle) and one bit-pair square root, all under a small sequencer.
// When the velocity ends at zero after integration, the friction steps (the
// square root and three direction divides) are skipped; otherwise six divides
// and the square root dominate the work of an item. Configuration writes are
// always taken and must only happen while the block is idle.
`default_nettype none

module rigid_body_euler_step (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [30:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] force_x,
	input  wire logic signed [31:0] force_y,
	input  wire logic signed [31:0] force_z,
	input  wire logic signed [31:0] extra_accel_x,
	input  wire logic signed [31:0] extra_accel_y,
	input  wire logic signed [31:0] extra_accel_z,
	input  wire logic [16:0]        time_step,
	input  wire logic signed [31:0] pos_x,
	input  wire logic signed [31:0] pos_y,
	input  wire logic signed [31:0] pos_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      new_pos_x,
	output logic signed [31:0]      new_pos_y,
	output logic signed [31:0]      new_pos_z,
	output logic signed [31:0]      vel_out_x,
	output logic signed [31:0]      vel_out_y,
	output logic signed [31:0]      vel_out_z
);
	import rbes_pkg::*;

	// configuration registers
	logic [30:0] mass_q, limx_q, limy_q;
	logic [30:0] fric_q [3];

	// sequencer
	state_t     state_q;
	logic [1:0] ax_q;
	logic       phase_q;   // divider use: 0 acceleration, 1 friction direction

	// latched item
	logic signed [31:0] f_q [3];
	logic signed [31:0] e_q [3];
	logic signed [31:0] p_q [3];
	logic [16:0]        dt_q;

	// body state and results
	logic signed [31:0] vel_q  [3];
	logic signed [31:0] npos_q [3];

	// working registers
	logic signed [31:0] a_q;
	logic [63:0]        sumv_q, msq_q;
	logic [31:0]        mag_q [3];
	logic [FRAC_BITS:0] d_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;

	// shared divider
	logic [DVD_W-1:0]  quo_q;
	logic [31:0]       rem_q, dvs_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [33:0]       trial;

	// square root
	logic [63:0] x_q, r_q, bit_q, rsum;
	logic [4:0]  rcnt_q;

	// combinational helpers
	logic [31:0]        vabs;
	logic [31:0]        tmag;
	logic signed [31:0] acc_a;
	logic signed [31:0] vel_zero_chk;
	logic               stop;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	assign new_pos_x = npos_q[0];
	assign new_pos_y = npos_q[1];
	assign new_pos_z = npos_q[2];
	assign vel_out_x = vel_q[0];
	assign vel_out_y = vel_q[1];
	assign vel_out_z = vel_q[2];

	assign vabs  = vel_q[ax_q][31] ? 32'(-vel_q[ax_q]) : 32'(vel_q[ax_q]);
	assign tmag  = prod_q[FRAC_BITS +: 32];
	assign trial = {1'b0, rem_q, quo_q[DVD_W-1]} - {2'b00, dvs_q};
	assign rsum  = r_q + bit_q;
	assign stop  = msq_q > sumv_q;
	assign vel_zero_chk = vel_q[0] | vel_q[1] | vel_q[2];

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_AMUL: begin
				mul_a = a_q[31] ? 32'(-a_q) : 32'(a_q);
				mul_b = 32'(dt_q);
			end
			S_SQM, S_MSM: begin
				mul_a = (state_q == S_SQM) ? vabs : mag_q[ax_q];
				mul_b = (state_q == S_SQM) ? vabs : mag_q[ax_q];
			end
			S_FS: begin
				mul_a = 32'(fric_q[ax_q]);
				mul_b = 32'(dt_q);
			end
			S_FD: begin
				mul_a = 32'(d_q);
				mul_b = tmag;
			end
			S_PM: begin
				mul_a = vabs;
				mul_b = 32'(dt_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// quotient to saturated acceleration plus the extra term
	always_comb begin
		logic signed [31:0] a0;
		if (!f_q[ax_q][31])
			a0 = (|quo_q[DVD_W-1:31]) ? 32'sh7FFF_FFFF : $signed(quo_q[31:0]);
		else
			a0 = (|quo_q[DVD_W-1:31]) ? 32'sh8000_0000 : $signed(32'(-quo_q[31:0]));
		acc_a = sat32(34'(a0) + 34'(e_q[ax_q]));
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// configuration writes; an index beyond the list is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q    <= MASS_RST;
			fric_q[0] <= FRIC_RST;
			fric_q[1] <= FRIC_RST;
			fric_q[2] <= FRIC_RST;
			limx_q    <= LIMX_RST;
			limy_q    <= LIMY_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASS:   mass_q    <= cfg_data;
				REG_FRIC_X: fric_q[0] <= cfg_data;
				REG_FRIC_Y: fric_q[1] <= cfg_data;
				REG_FRIC_Z: fric_q[2] <= cfg_data;
				REG_LIM_X:  limx_q    <= cfg_data;
				REG_LIM_Y:  limy_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ax_q     <= '0;
			phase_q  <= 1'b0;
			vel_q[0] <= '0;
			vel_q[1] <= '0;
			vel_q[2] <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						ax_q    <= '0;
						state_q <= S_ALD;
					end
				end
				S_ALD: begin
					phase_q <= 1'b0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (dcnt_q == '0)
						state_q <= phase_q ? S_FS : S_ACC;
				end
				S_ACC: state_q <= S_AMUL;
				S_AMUL: state_q <= S_AVEL;
				S_AVEL: begin
					// add the truncated a*dt to the stored velocity
					vel_q[ax_q] <= sat32(34'(vel_q[ax_q]) +
						(a_q[31] ? -34'(tmag) : 34'(tmag)));
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_VCHK;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_ALD;
					end
				end
				S_VCHK: begin
					// a body at rest skips friction
					state_q <= (vel_zero_chk == '0) ? S_CLAMP : S_SQM;
				end
				S_SQM: state_q <= S_SQA;
				S_SQA: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_ROOT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_SQM;
					end
				end
				S_ROOT: begin
					if (rcnt_q == '0)
						state_q <= S_FLD;
				end
				S_FLD: begin
					phase_q <= 1'b1;
					state_q <= S_DIV;
				end
				S_FS: state_q <= S_FD;
				S_FD: state_q <= S_FM;
				S_FM: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_MSM;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_FLD;
					end
				end
				S_MSM: state_q <= S_MSA;
				S_MSA: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_FAPP;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_MSM;
					end
				end
				S_FAPP: begin
					// stop the body, or pull each axis toward zero
					for (int i = 0; i < 3; i++) begin
						if (stop)
							vel_q[i] <= '0;
						else if (vel_q[i] > 0)
							vel_q[i] <= sat32(34'(vel_q[i]) - 34'(mag_q[i]));
						else if (vel_q[i] < 0)
							vel_q[i] <= sat32(34'(vel_q[i]) + 34'(mag_q[i]));
					end
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					// limit x and y magnitude, keep the sign
					if ((vel_q[0][31] ? 32'(-vel_q[0]) : 32'(vel_q[0])) > {1'b0, limx_q})
						vel_q[0] <= vel_q[0][31] ? -$signed({1'b0, limx_q})
							: $signed({1'b0, limx_q});
					if ((vel_q[1][31] ? 32'(-vel_q[1]) : 32'(vel_q[1])) > {1'b0, limy_q})
						vel_q[1] <= vel_q[1][31] ? -$signed({1'b0, limy_q})
							: $signed({1'b0, limy_q});
					ax_q    <= '0;
					state_q <= S_PM;
				end
				S_PM: state_q <= S_PA;
				S_PA: begin
					if (ax_q == 2'd2) begin
						ax_q    <= '0;
						state_q <= S_OUT;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= S_PM;
					end
				end
				S_OUT: begin
					if (out_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				f_q[0] <= force_x;
				f_q[1] <= force_y;
				f_q[2] <= force_z;
				e_q[0] <= extra_accel_x;
				e_q[1] <= extra_accel_y;
				e_q[2] <= extra_accel_z;
				p_q[0] <= pos_x;
				p_q[1] <= pos_y;
				p_q[2] <= pos_z;
				dt_q   <= time_step;
				sumv_q <= '0;
				msq_q  <= '0;
			end
			S_ALD: begin
				// |force| scaled up, over mass; zero mass divides by a raw one (one LSB)
				quo_q  <= {(f_q[ax_q][31] ? 32'(-f_q[ax_q]) : 32'(f_q[ax_q])),
					{FRAC_BITS{1'b0}}};
				dvs_q  <= (mass_q == '0) ? 32'd1 : 32'(mass_q);
				rem_q  <= '0;
				dcnt_q <= DCNT_W'(DVD_W - 1);
			end
			S_DIV: begin
				if (!trial[33]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[DVD_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[DVD_W-1]};
					quo_q <= {quo_q[DVD_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - DCNT_W'(1);
			end
			S_ACC: a_q <= acc_a;
			S_SQA: begin
				sumv_q <= sumv_q + prod_q;
				x_q    <= sumv_q + prod_q;
				r_q    <= '0;
				bit_q  <= 64'd1 << 62;
				rcnt_q <= 5'd31;
			end
			S_ROOT: begin
				if (x_q >= rsum) begin
					x_q <= x_q - rsum;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				rcnt_q <= rcnt_q - 5'd1;
			end
			S_FLD: begin
				// unit direction component: |v| scaled up over the length
				quo_q  <= {vabs, {FRAC_BITS{1'b0}}};
				dvs_q  <= r_q[31:0];
				rem_q  <= '0;
				dcnt_q <= DCNT_W'(DVD_W - 1);
			end
			S_FS: d_q <= quo_q[FRAC_BITS:0];
			S_FM: mag_q[ax_q] <= tmag;
			S_MSA: msq_q <= msq_q + prod_q;
			S_PA: npos_q[ax_q] <= sat32(34'(p_q[ax_q]) +
				(vel_q[ax_q][31] ? -34'(tmag) : 34'(tmag)));
			default: ;
		endcase
	end

	// result is held only while no new item can enter
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("result pending while input open");

	// axis counter stays within three axes
	assert property (@(posedge clk) disable iff (!arst_n) ax_q != 2'd3)
		else $error("axis counter out of range");

	// an accepted item closes the input
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input open after transfer");

	// x velocity only changes while an item is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q == S_IDLE) && (state_q == S_IDLE) |-> $stable(vel_q[0]))
		else $error("velocity moved while idle");

endmodule

`default_nettype wire

// ----- test/rigid_body_euler_step_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rigid_body_euler_step_test: self-checking bench for the Euler step block
// Drives force/acceleration/position ticks through the valid/ready channel,
// predicts velocity and position with a local fixed-point model of the block,
// and compares every result transfer field by field. Registers are rewritten
// between phases while the block is idle, covering their extremes.
// ----------------------------------------------------------------------------
`default_nettype none

module rigid_body_euler_step_test;
	import rbes_pkg::*;

	localparam int QB = FRAC_BITS;
	localparam longint CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic signed [31:0] fx, fy, fz, ax, ay, az;
		logic [16:0]        dt;
		logic signed [31:0] px, py, pz;
	} tick_t;

	typedef struct packed {
		logic signed [31:0] px, py, pz, vx, vy, vz;
	} body_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	tick_t drv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] new_pos_x, new_pos_y, new_pos_z;
	logic signed [31:0] vel_out_x, vel_out_y, vel_out_z;

	// predictor state and register copies
	longint m_mass, m_fric [3], m_lim_x, m_lim_y;
	longint m_vel [3];
	body_t expected_bodies [$];
	int mismatches = 0;
	int results_seen = 0;
	longint cycles = 0;

	rigid_body_euler_step dut (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready,
		.force_x(drv.fx), .force_y(drv.fy), .force_z(drv.fz),
		.extra_accel_x(drv.ax), .extra_accel_y(drv.ay), .extra_accel_z(drv.az),
		.time_step(drv.dt), .pos_x(drv.px), .pos_y(drv.py), .pos_z(drv.pz),
		.out_valid, .out_ready,
		.new_pos_x, .new_pos_y, .new_pos_z, .vel_out_x, .vel_out_y, .vel_out_z
	);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic longint sat(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// truncating shift toward zero
	function automatic longint qdown(input longint v);
		return v / (64'sd1 <<< QB);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned x);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag64(input longint v);
		return v < 0 ? longint'(-v) : longint'(v);
	endfunction

	// advance the body by one tick and return the result it should produce
	function automatic body_t euler_step(input tick_t t);
		longint mass, dt, a, f, p;
		longint v [3];
		logic signed [31:0] fv [3], av [3], pv [3];
		longint unsigned sumv, len, d, s, hi, lo, sq;
		longint unsigned mg [3];
		bit halt;
		body_t r;
		mass = m_mass == 0 ? 1 : m_mass;
		dt = longint'(t.dt);
		fv = '{t.fx, t.fy, t.fz};
		av = '{t.ax, t.ay, t.az};
		pv = '{t.px, t.py, t.pz};
		for (int i = 0; i < 3; i++) begin
			f = longint'(fv[i]);
			a = sat((f * (64'sd1 <<< QB)) / mass);
			a = sat(a + longint'(av[i]));
			v[i] = sat(m_vel[i] + qdown(a * dt));
		end
		if (v[0] != 0 || v[1] != 0 || v[2] != 0) begin
			sumv = 0;
			hi = 0;
			lo = 0;
			halt = 1'b0;
			for (int i = 0; i < 3; i++) sumv += longint'(v[i] * v[i]);
			len = int_sqrt(sumv);
			for (int i = 0; i < 3; i++) begin
				d = (mag64(v[i]) << QB) / len;
				s = (longint'(m_fric[i]) * dt) >> QB;
				mg[i] = (d * s) >> QB;
				if (mg[i] > 64'hFFFF_FFFF) halt = 1'b1;
			end
			if (!halt) begin
				for (int i = 0; i < 3; i++) begin
					sq = mg[i] * mg[i];
					lo += sq;
					if (lo < sq) hi++;
				end
				if (hi != 0 || lo > sumv) halt = 1'b1;
			end
			for (int i = 0; i < 3; i++) begin
				if (halt) v[i] = 0;
				else if (v[i] > 0) v[i] = sat(v[i] - longint'(mg[i]));
				else if (v[i] < 0) v[i] = sat(v[i] + longint'(mg[i]));
			end
		end
		// speed clamp on x and y only
		if (mag64(v[0]) > m_lim_x) v[0] = v[0] < 0 ? -m_lim_x : m_lim_x;
		if (mag64(v[1]) > m_lim_y) v[1] = v[1] < 0 ? -m_lim_y : m_lim_y;
		for (int i = 0; i < 3; i++) begin
			p = sat(longint'(pv[i]) + qdown(v[i] * dt));
			pv[i] = p[31:0];
			m_vel[i] = v[i];
		end
		r.px = pv[0];
		r.py = pv[1];
		r.pz = pv[2];
		r.vx = v[0][31:0];
		r.vy = v[1][31:0];
		r.vz = v[2][31:0];
		return r;
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) @(posedge clk);
	endtask

	// hold valid across back-to-back items; drop it only for a drawn gap
	task automatic send_tick(input tick_t t);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap != 0) begin
			in_valid <= 1'b0;
			idle_cycles(gap);
		end
		in_valid <= 1'b1;
		drv <= t;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_bodies.push_back(euler_step(t));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_bodies.size() != 0) @(posedge clk);
		idle_cycles(8);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [30:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_MASS:   m_mass = val;
			REG_FRIC_X: m_fric[0] = val;
			REG_FRIC_Y: m_fric[1] = val;
			REG_FRIC_Z: m_fric[2] = val;
			REG_LIM_X:  m_lim_x = val;
			REG_LIM_Y:  m_lim_y = val;
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [30:0] mass, input logic [30:0] fr,
			input logic [30:0] lx, input logic [30:0] ly);
		wait_drained();
		write_reg(REG_MASS, mass);
		write_reg(REG_FRIC_X, fr);
		write_reg(REG_FRIC_Y, fr >> 1);
		write_reg(REG_FRIC_Z, fr >> 2);
		write_reg(REG_LIM_X, lx);
		write_reg(REG_LIM_Y, ly);
	endtask

	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 16'hFFFF);
			3: return -$urandom_range(0, 16'hFFFF);
			default: return $urandom;
		endcase
	endfunction

	function automatic tick_t rnd_tick(input bit mild);
		tick_t t;
		t.fx = mild ? $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000 : rnd_word();
		t.fy = mild ? $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000 : rnd_word();
		t.fz = mild ? $signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000 : rnd_word();
		t.ax = rnd_word();
		t.ay = rnd_word();
		t.az = rnd_word();
		case ($urandom_range(0, 3))
			0: t.dt = 17'h10000;
			1: t.dt = 17'd0;
			default: t.dt = 17'($urandom_range(0, 17'h10000));
		endcase
		t.px = rnd_word();
		t.py = rnd_word();
		t.pz = rnd_word();
		return t;
	endfunction

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		body_t got, want;
		if (out_valid && out_ready) begin
			got = '{new_pos_x, new_pos_y, new_pos_z, vel_out_x, vel_out_y, vel_out_z};
			results_seen <= results_seen + 1;
			if (expected_bodies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_bodies.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected pos %0d %0d %0d vel %0d %0d %0d, got pos %0d %0d %0d vel %0d %0d %0d",
							want.px, want.py, want.pz, want.vx, want.vy, want.vz,
							got.px, got.py, got.pz, got.vx, got.vy, got.vz);
				end
			end
		end
	end

	// stall each result a drawn number of cycles, with zero-stall stretches
	initial begin
		int gap;
		forever begin
			@(posedge clk);
			if (out_valid) begin
				gap = (cycles / 20000) % 3 == 1 ? 0 : $urandom_range(0, 3);
				idle_cycles(gap);
				out_ready <= 1'b1;
				@(posedge clk);
				out_ready <= 1'b0;
			end
		end
	end

	task automatic test_directed();
		tick_t t;
		t = '0;
		t.dt = 17'h10000;
		send_tick(t);                    // zero velocity, position unchanged
		t.fx = 32'sh0001_0000; t.px = 32'sh7FFF_FFFF;
		send_tick(t);
		t = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 17'h10000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000};
		send_tick(t);                    // saturation everywhere
		t.dt = 17'd1;
		send_tick(t);
		t.dt = 17'h0FFFF;
		send_tick(t);
		t = '0;
		t.az = 32'sh0300_0000; t.dt = 17'h08000;
		send_tick(t);                    // z is never clamped
		wait_drained();                  // hold off until the block is empty
		write_all(31'd0, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF); // zero mass, no friction
		t = '0; t.fx = 32'sh0000_0001; t.dt = 17'h10000;
		send_tick(t);
		t.fx = 32'sh8000_0000;
		send_tick(t);
		write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 31'd0); // huge friction
		t = '0; t.ax = 32'sh0010_0000; t.ay = -32'sh0004_0000; t.dt = 17'h10000;
		send_tick(t);
		send_tick(t);
		wait_drained();
		write_reg(reg_idx_t'(3'd6), 31'h1234);  // out of range, ignored
		write_reg(reg_idx_t'(3'd7), 31'h5678);
	endtask

	task automatic test_random(input int n, input bit mild);
		repeat (n) send_tick(rnd_tick(mild));
	endtask

	initial begin
		m_mass = MASS_RST;
		m_fric = '{FRIC_RST, FRIC_RST, FRIC_RST};
		m_lim_x = LIMX_RST;
		m_lim_y = LIMY_RST;
		m_vel = '{0, 0, 0};
		idle_cycles(3);
		arst_n <= 1'b1;
		idle_cycles(2);
		test_directed();
		write_all(MASS_RST, FRIC_RST, LIMX_RST, LIMY_RST);
		test_random(200, 1'b1);
		write_all(31'd1, 31'd3, 31'h0100_0000, 31'h7FFF_FFFF);
		test_random(200, 1'b0);
		write_all(31'h0020_0000, 31'h0001_0000, 31'h7FFF_FFFF, 31'd65536);
		test_random(250, 1'b1);
		write_all(31'h7FFF_FFFF, 31'd0, 31'd0, 31'd0);
		test_random(100, 1'b0);
		write_all(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
		test_random(190, 1'b1);
		wait_drained();
		idle_cycles(400);
		$display("covered %0d result transfers over eight register settings", results_seen);
		$display("mismatches: %0d, leftover expectations: %0d",
			mismatches, expected_bodies.size());
		if (mismatches == 0 && expected_bodies.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
